[rtl/sbm_pkg.sv]
// Shared types and constants of the serial bank mapper.
`timescale 1ns / 1ps

package sbm_pkg;

    localparam int CFG_ADDR_W = 2;
    localparam logic [CFG_ADDR_W-1:0] CFG_ADDR_LARGE_PRG = 2'd0;

    localparam logic [2:0] SHIFT_LAST = 3'd4;
    localparam logic [1:0] MIRROR_RESET = 2'd3;
    localparam logic [4:0] CHR_BANK_RESET = 5'd31;
    localparam logic [3:0] PRG_FIXED_LAST = 4'hF;

    typedef enum logic [1:0] {
        SEL_CONTROL = 2'd0,
        SEL_CHR0    = 2'd1,
        SEL_CHR1    = 2'd2,
        SEL_PRG     = 2'd3
    } reg_sel_t;

    typedef struct packed {
        logic [15:0] cpu_address;
        logic [7:0]  write_data;
        logic        same_cycle;
    } in_item_t;

    typedef struct packed {
        logic [1:0] mirroring;
        logic [4:0] prg_page_low;
        logic [4:0] prg_page_high;
        logic [4:0] chr_page_low;
        logic [5:0] chr_page_high;
        logic       wram_enable;
    } out_item_t;

    // Bank registers that the page decode looks at.
    typedef struct packed {
        logic [1:0] mirror_mode;
        logic       fix_last_slot;
        logic       prg_16k_mode;
        logic       chr_4k_mode;
        logic [4:0] chr_bank_first;
        logic [4:0] chr_bank_second;
        logic [3:0] prg_bank;
        logic       wram_disabled;
        logic       last_chr_was_second;
    } map_state_t;

endpackage

[rtl/sbm_regs.sv]
// Serial shift loader and bank registers of the mapper.
`timescale 1ns / 1ps

module sbm_regs
    import sbm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  in_item_t   item,
    output map_state_t map_next
);

    logic [4:0] shift_buffer_reg, shift_buffer_next;
    logic [2:0] shift_count_reg, shift_count_next;
    map_state_t map_reg;
    logic [4:0] loaded;
    reg_sel_t   sel;

    assign loaded = {item.write_data[0], shift_buffer_reg[4:1]};
    assign sel    = reg_sel_t'(item.cpu_address[14:13]);

    always_comb
    begin
        shift_buffer_next = shift_buffer_reg;
        shift_count_next  = shift_count_reg;
        map_next          = map_reg;
        if (item.write_data[7])
        begin
            shift_buffer_next      = '0;
            shift_count_next       = '0;
            map_next.prg_16k_mode  = 1'b1;
            map_next.fix_last_slot = 1'b1;
        end
        else if (!item.same_cycle)
        begin
            if (shift_count_reg == SHIFT_LAST)
            begin
                // Fifth bit: the full value goes to the register picked by the address.
                shift_buffer_next = '0;
                shift_count_next  = '0;
                case (sel)
                    SEL_CONTROL:
                    begin
                        map_next.mirror_mode   = loaded[1:0];
                        map_next.fix_last_slot = loaded[2];
                        map_next.prg_16k_mode  = loaded[3];
                        map_next.chr_4k_mode   = loaded[4];
                    end
                    SEL_CHR0:
                    begin
                        map_next.last_chr_was_second = 1'b0;
                        map_next.chr_bank_first      = loaded;
                    end
                    SEL_CHR1:
                    begin
                        map_next.last_chr_was_second = 1'b1;
                        map_next.chr_bank_second     = loaded;
                    end
                    default:
                    begin
                        map_next.prg_bank      = loaded[3:0];
                        map_next.wram_disabled = loaded[4];
                    end
                endcase
            end
            else
            begin
                shift_buffer_next = loaded;
                shift_count_next  = shift_count_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_buffer_reg             <= '0;
            shift_count_reg              <= '0;
            map_reg.mirror_mode          <= MIRROR_RESET;
            map_reg.fix_last_slot        <= 1'b1;
            map_reg.prg_16k_mode         <= 1'b1;
            map_reg.chr_4k_mode          <= 1'b1;
            map_reg.chr_bank_first       <= CHR_BANK_RESET;
            map_reg.chr_bank_second      <= CHR_BANK_RESET;
            map_reg.prg_bank             <= '0;
            map_reg.wram_disabled        <= 1'b0;
            map_reg.last_chr_was_second  <= 1'b0;
        end
        else if (step)
        begin
            shift_buffer_reg <= shift_buffer_next;
            shift_count_reg  <= shift_count_next;
            map_reg          <= map_next;
        end
    end

endmodule

[rtl/sbm_pages.sv]
// Page decode from the bank registers to the reported mapping.
`timescale 1ns / 1ps

module sbm_pages
    import sbm_pkg::*;
(
    input  map_state_t map,
    input  logic       large_prg_rom,
    output out_item_t  pages
);

    logic [4:0] extra;
    logic       hi_sel;
    logic [4:0] p0;
    logic [4:0] p1;
    logic [4:0] c0;

    always_comb
    begin
        extra  = (map.last_chr_was_second && map.chr_4k_mode) ?
                 map.chr_bank_second : map.chr_bank_first;
        hi_sel = large_prg_rom & extra[4];

        if (map.prg_16k_mode)
        begin
            if (map.fix_last_slot)
            begin
                p0 = {hi_sel, map.prg_bank};
                p1 = {hi_sel, PRG_FIXED_LAST};
            end
            else
            begin
                p0 = {hi_sel, 4'd0};
                p1 = {hi_sel, map.prg_bank};
            end
        end
        else
        begin
            p0 = {hi_sel, map.prg_bank[3:1], 1'b0};
            p1 = p0 + 5'd1;
        end

        pages.mirroring     = map.mirror_mode;
        pages.prg_page_low  = p0;
        pages.prg_page_high = p1;
        pages.wram_enable   = !map.wram_disabled;

        if (map.chr_4k_mode)
        begin
            c0                  = map.chr_bank_first;
            pages.chr_page_high = {1'b0, map.chr_bank_second};
        end
        else
        begin
            c0                  = {map.chr_bank_first[4:1], 1'b0};
            pages.chr_page_high = {1'b0, c0} + 6'd1;
        end
        pages.chr_page_low = c0;
    end

endmodule

[rtl/serial_bank_mapper_core.sv]
// Top level of the serial bank mapper: input stage, register update, result stage, APB port.
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | in_item (cpu_address, write_data, same_cycle)
//  out     | output    | out_valid/out_stall| out_item (mapping after the write)
//  apb     | slave     | psel/penable/pready| large_prg_rom at byte address 0
//
// One transaction per cycle sustained while the output does not stall; a write's result passes
// the input register, then one pass of shift/decode logic into the result register, before it
// is offered.
// Reset puts the bank registers into their power-up mapping with no transaction pending.
// A stall on the output holds the result register and then the input register; in_stall
// rises only when both stages are full.
`timescale 1ns / 1ps

module serial_bank_mapper_core
    import sbm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_item_t              in_item,

    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_item,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic       in_valid_reg;
    in_item_t   in_item_reg;
    logic       out_valid_reg;
    out_item_t  out_item_reg;
    logic       large_prg_rom_reg;
    logic       advance;
    logic       accept;
    map_state_t map_next;
    out_item_t  pages;

    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    assign pready = 1'b1;
    assign prdata = (paddr == CFG_ADDR_LARGE_PRG) ? {31'd0, large_prg_rom_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            large_prg_rom_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && pready && (paddr == CFG_ADDR_LARGE_PRG))
        begin
            large_prg_rom_reg <= pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_item_reg <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_item_reg <= pages;
        end
    end

    sbm_regs u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (advance),
        .item     (in_item_reg),
        .map_next (map_next)
    );

    sbm_pages u_pages (
        .map           (map_next),
        .large_prg_rom (large_prg_rom_reg),
        .pages         (pages)
    );

endmodule

[tb/tb_serial_bank_mapper_core.sv]
// Self-checking testbench of the serial bank mapper core with a cycle-free mapping predictor.
`timescale 1ns / 1ps

module tb_serial_bank_mapper_core;
    import sbm_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 4;
    localparam int MAX_REPORTS    = 10;
    localparam int PHASE_ITEMS    = 240;
    localparam int NUM_PHASES     = 5;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    in_item_t              in_item   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_item_t             out_item;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr     = '0;
    logic [31:0]           pwdata    = '0;
    logic [31:0]           prdata;
    logic                  pready;

    serial_bank_mapper_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // Predictor state: bank registers, serial shifter and the ROM size setting.
    map_state_t bank_regs;
    logic [4:0] shift_buf;
    logic [2:0] shift_cnt;
    logic       large_prg;

    in_item_t   pending_writes[$];
    out_item_t  map_expected[$];
    out_item_t  want_map;

    bit in_took    = 1'b0;
    bit idling_on  = 1'b1;
    int in_gap     = 0;
    int stall_left = 0;
    int idle_count = 0;
    int errors     = 0;
    int n_writes   = 0;
    int n_resets   = 0;
    int n_ignored  = 0;
    int n_loads    = 0;
    int n_large    = 0;
    int n_results  = 0;

    function automatic in_item_t mk_item(logic [15:0] a, logic [7:0] d, logic s);
        return in_item_t'{cpu_address: a, write_data: d, same_cycle: s};
    endfunction

    function automatic logic [15:0] rand_addr(logic [1:0] sel);
        logic top;
        // Bit 15 is not decoded, so it is cleared now and then.
        top = ($urandom_range(0, 15) != 0);
        return {top, sel, 13'($urandom)};
    endfunction

    function automatic string map_str(out_item_t m);
        return $sformatf("mir=%0d prg=%0d/%0d chr=%0d/%0d wram=%0b", m.mirroring,
                         m.prg_page_low, m.prg_page_high, m.chr_page_low,
                         m.chr_page_high, m.wram_enable);
    endfunction

    // Applies one CPU write to the predictor and returns the mapping that follows it.
    function automatic out_item_t map_after_write(in_item_t w);
        out_item_t  r;
        logic [4:0] extra;
        logic [4:0] hi_sel;
        logic [4:0] p0;
        logic [4:0] p1;
        logic [4:0] c0;
        logic [5:0] c1;
        n_writes++;
        if (large_prg)
            n_large++;
        if (w.write_data[7]) begin
            n_resets++;
            shift_buf = '0;
            shift_cnt = '0;
            bank_regs.prg_16k_mode  = 1'b1;
            bank_regs.fix_last_slot = 1'b1;
        end
        else if (w.same_cycle) begin
            n_ignored++;
        end
        else begin
            shift_buf = {w.write_data[0], shift_buf[4:1]};
            if (shift_cnt == SHIFT_LAST) begin
                n_loads++;
                case (reg_sel_t'(w.cpu_address[14:13]))
                    SEL_CONTROL: begin
                        bank_regs.mirror_mode   = shift_buf[1:0];
                        bank_regs.fix_last_slot = shift_buf[2];
                        bank_regs.prg_16k_mode  = shift_buf[3];
                        bank_regs.chr_4k_mode   = shift_buf[4];
                    end
                    SEL_CHR0: begin
                        bank_regs.last_chr_was_second = 1'b0;
                        bank_regs.chr_bank_first      = shift_buf;
                    end
                    SEL_CHR1: begin
                        bank_regs.last_chr_was_second = 1'b1;
                        bank_regs.chr_bank_second     = shift_buf;
                    end
                    default: begin
                        bank_regs.prg_bank      = shift_buf[3:0];
                        bank_regs.wram_disabled = shift_buf[4];
                    end
                endcase
                shift_buf = '0;
                shift_cnt = '0;
            end
            else begin
                shift_cnt = shift_cnt + 3'd1;
            end
        end

        extra  = (bank_regs.last_chr_was_second && bank_regs.chr_4k_mode) ?
                 bank_regs.chr_bank_second : bank_regs.chr_bank_first;
        hi_sel = {large_prg & extra[4], 4'b0000};

        if (bank_regs.prg_16k_mode) begin
            if (bank_regs.fix_last_slot) begin
                p0 = {1'b0, bank_regs.prg_bank} | hi_sel;
                p1 = {1'b0, PRG_FIXED_LAST} | hi_sel;
            end
            else begin
                p0 = hi_sel;
                p1 = {1'b0, bank_regs.prg_bank} | hi_sel;
            end
        end
        else begin
            p0 = {1'b0, bank_regs.prg_bank[3:1], 1'b0} | hi_sel;
            p1 = p0 + 5'd1;
        end

        if (bank_regs.chr_4k_mode) begin
            c0 = bank_regs.chr_bank_first;
            c1 = {1'b0, bank_regs.chr_bank_second};
        end
        else begin
            c0 = {bank_regs.chr_bank_first[4:1], 1'b0};
            c1 = {1'b0, c0} + 6'd1;
        end

        r.mirroring     = bank_regs.mirror_mode;
        r.prg_page_low  = p0;
        r.prg_page_high = p1;
        r.chr_page_low  = c0;
        r.chr_page_high = c1;
        r.wram_enable   = ~bank_regs.wram_disabled;
        return r;
    endfunction

    task automatic report_error(string msg);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    // Mostly complete five-bit loads with random filler bits, mixed with reset writes,
    // same-cycle writes, truncated loads and unconstrained writes.
    task automatic add_random_items(int n);
        int         added;
        int         kind;
        int         nbits;
        logic [1:0] sel;
        logic [4:0] val;
        added = 0;
        while (added < n) begin
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
                sel = 2'($urandom);
                val = 5'($urandom);
                case ($urandom_range(0, 7))
                    0: val = '0;
                    1: val = '1;
                    default: ;
                endcase
                nbits = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4) : 5;
                for (int i = 0; i < nbits; i++) begin
                    if ($urandom_range(0, 15) == 0) begin
                        pending_writes.push_back(mk_item(rand_addr(2'($urandom)),
                                                         {1'b0, 7'($urandom)}, 1'b1));
                        added++;
                    end
                    pending_writes.push_back(mk_item(rand_addr(i == 4 ? sel : 2'($urandom)),
                                                     {1'b0, 6'($urandom), val[i]}, 1'b0));
                    added++;
                end
                // A cut-short load is followed by a reset write to realign the shifter.
                if (nbits < 5) begin
                    pending_writes.push_back(mk_item(rand_addr(2'($urandom)),
                                                     {1'b1, 7'($urandom)}, 1'($urandom)));
                    added++;
                end
            end
            else if (kind == 7) begin
                pending_writes.push_back(mk_item(rand_addr(2'($urandom)),
                                                 {1'b1, 7'($urandom)}, 1'($urandom)));
                added++;
            end
            else if (kind == 8) begin
                pending_writes.push_back(mk_item(rand_addr(2'($urandom)),
                                                 {1'b0, 7'($urandom)}, 1'b1));
                added++;
            end
            else begin
                pending_writes.push_back(mk_item(16'($urandom), 8'($urandom), 1'($urandom)));
                added++;
            end
        end
    endtask

    task automatic wait_idle();
        while (pending_writes.size() != 0 || in_valid || map_expected.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_large_prg(logic v);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = CFG_ADDR_LARGE_PRG;
        pwdata  = {31'd0, v};
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        large_prg = v;
    endtask

    initial begin
        forever #5 clk = ~clk;
    end

    // Input driver: a new transaction is offered only after the previous one was taken.
    always @(negedge clk) begin
        if (rst_n && (!in_valid || in_took)) begin
            if (in_gap > 0) begin
                in_gap--;
                in_valid <= 1'b0;
            end
            else if (pending_writes.size() == 0) begin
                in_valid <= 1'b0;
            end
            else if (idling_on && $urandom_range(0, 5) == 0) begin
                in_gap = $urandom_range(0, 9);
                in_valid <= 1'b0;
            end
            else begin
                in_item  <= pending_writes.pop_front();
                in_valid <= 1'b1;
            end
        end
    end

    // Output back-pressure in bursts.
    always @(negedge clk) begin
        if (stall_left > 0) begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (rst_n && idling_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 9);
            out_stall <= 1'b1;
        end
        else begin
            out_stall <= 1'b0;
        end
    end

    // Monitor, checker and watchdog.
    always @(posedge clk) begin
        if (rst_n) begin
            in_took = in_valid && !in_stall;
            if (out_valid && !out_stall) begin
                n_results++;
                if (map_expected.size() == 0) begin
                    report_error($sformatf("result with nothing expected: %s",
                                           map_str(out_item)));
                end
                else begin
                    want_map = map_expected.pop_front();
                    if (out_item !== want_map)
                        report_error($sformatf("mapping mismatch: expected %s, got %s",
                                               map_str(want_map), map_str(out_item)));
                end
            end
            if (in_took)
                map_expected.push_back(map_after_write(in_item));
            if (in_took || (out_valid && !out_stall) || psel)
                idle_count = 0;
            else
                idle_count++;
            if (idle_count >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("tb_serial_bank_mapper_core NOT OK");
                $finish;
            end
        end
    end

    initial begin
        bank_regs = '{mirror_mode: MIRROR_RESET, fix_last_slot: 1'b1, prg_16k_mode: 1'b1,
                      chr_4k_mode: 1'b1, chr_bank_first: CHR_BANK_RESET,
                      chr_bank_second: CHR_BANK_RESET, prg_bank: 4'd0, wram_disabled: 1'b0,
                      last_chr_was_second: 1'b0};
        shift_buf = '0;
        shift_cnt = '0;
        large_prg = 1'b0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: a reset write flagged as same cycle still takes effect.
        pending_writes.push_back(mk_item(16'hFFFF, 8'hFF, 1'b1));
        // Control = 0: 32KB program mode, 8KB pattern mode; data bits 6..1 are noise.
        for (int i = 0; i < 5; i++)
            pending_writes.push_back(mk_item(16'h8000, 8'h7E, 1'b0));
        pending_writes.push_back(mk_item(16'hE000, 8'h01, 1'b1));
        // PRG = all ones: bank 15 and work RAM disabled.
        for (int i = 0; i < 5; i++)
            pending_writes.push_back(mk_item(16'hFFFF, 8'h01, 1'b0));
        // CHR0 = all ones, the last write below $8000.
        for (int i = 0; i < 5; i++)
            pending_writes.push_back(mk_item(i == 4 ? 16'h2000 : 16'hA000, 8'h7F, 1'b0));
        for (int i = 0; i < 5; i++)
            pending_writes.push_back(mk_item(16'hDFFF, 8'h00, 1'b0));
        pending_writes.push_back(mk_item(16'h8000, 8'h80, 1'b0));
        wait_idle();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph == NUM_PHASES - 1)
                idling_on = 1'b0;
            write_large_prg(ph[0] == 1'b0);
            add_random_items(PHASE_ITEMS);
            wait_idle();
        end
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (map_expected.size() != 0)
            report_error($sformatf("%0d results never arrived", map_expected.size()));
        $display("Ran %0d CPU writes (%0d reset, %0d same-cycle ignored, %0d register loads),",
                 n_writes, n_resets, n_ignored, n_loads);
        $display("%0d under the 512KB setting; %0d mappings checked, %0d errors.",
                 n_large, n_results, errors);
        if (errors == 0)
            $display("tb_serial_bank_mapper_core OK");
        else
            $display("tb_serial_bank_mapper_core NOT OK");
        $finish;
    end

endmodule
